@@ hw/rtl/ecpr_pkg.sv @@
// Shared types and constants for the enhanced second-chance page replacement block.
package ecpr_pkg;

  localparam int unsigned FRAMES    = 4;
  localparam int unsigned PAGE_BITS = 8;
  localparam int unsigned IDX_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1;

  localparam int unsigned IN_BITS   = PAGE_BITS + 1;
  localparam int unsigned IN_W      = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_BITS  = 1 + IDX_W + 1 + PAGE_BITS + 1;
  localparam int unsigned OUT_W     = ((OUT_BITS + 7) / 8) * 8;

  // What an access does to the frame table
  typedef enum logic [4:0] {
    MODE_HIT  = 5'b00001,  // page resident
    MODE_FILL = 5'b00010,  // first empty frame takes the page
    MODE_VIC0 = 5'b00100,  // victim: first frame with ref=0, mod=0
    MODE_VIC1 = 5'b01000,  // victim: first frame with ref=0, mod=1
    MODE_VICM = 5'b10000   // all refs set: clear all, victim by mod bit only
  } mode_e;

  // Prefix flags handed down the row: "some earlier frame has ..."
  typedef struct packed {
    logic hit;
    logic inv;
    logic c0;
    logic c1;
    logic m0;
  } flag_t;

  // Data of the selected frame, collected down the row
  typedef struct packed {
    logic [IDX_W-1:0]     idx;
    logic [PAGE_BITS-1:0] page;
    logic                 dirty;
  } sel_t;

  // Access control broadcast to every frame cell
  typedef struct packed {
    logic  go;
    logic  wr;
    logic  any_m0;
    mode_e mode;
  } ctl_t;

  // Per-frame status seen by the top level
  typedef struct packed {
    logic valid;
    logic ref_bit;
  } stat_t;

  typedef struct packed {
    logic                 evicted_dirty;
    logic [PAGE_BITS-1:0] evicted_page;
    logic                 evicted_valid;
    logic [IDX_W-1:0]     frame_index;
    logic                 hit;
  } res_t;

endpackage

@@ hw/rtl/ecpr_cell.sv @@
// One frame of the table: page tag, valid, reference and modified bits.
module ecpr_cell import ecpr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [IDX_W-1:0]     idx_i,
  input  logic [PAGE_BITS-1:0] page_i,
  input  ctl_t                 ctl_i,
  input  flag_t                flag_i,
  output flag_t                flag_o,
  input  sel_t                 sel_i,
  output sel_t                 sel_o,
  output stat_t                stat_o
);

  logic                 valid_q, valid_d;
  logic                 ref_q, ref_d;
  logic                 mod_q, mod_d;
  logic [PAGE_BITS-1:0] page_q, page_d;

  logic match, c0, c1, m0, sel;

  assign match = valid_q && (page_q == page_i);
  assign c0    = valid_q && !ref_q && !mod_q;
  assign c1    = valid_q && !ref_q && mod_q;
  assign m0    = !mod_q;

  assign flag_o.hit = flag_i.hit | match;
  assign flag_o.inv = flag_i.inv | !valid_q;
  assign flag_o.c0  = flag_i.c0 | c0;
  assign flag_o.c1  = flag_i.c1 | c1;
  assign flag_o.m0  = flag_i.m0 | m0;

  always_comb begin
    unique case (ctl_i.mode)
      MODE_HIT:  sel = match;
      MODE_FILL: sel = !valid_q && !flag_i.inv;
      MODE_VIC0: sel = c0 && !flag_i.c0;
      MODE_VIC1: sel = c1 && !flag_i.c1;
      MODE_VICM: sel = ctl_i.any_m0 ? (m0 && !flag_i.m0) : (idx_i == '0);
      default:   sel = 1'b0;
    endcase
  end

  assign sel_o.idx   = sel_i.idx | (sel ? idx_i : '0);
  assign sel_o.page  = sel_i.page | (sel ? page_q : '0);
  assign sel_o.dirty = sel_i.dirty | (sel & mod_q);

  assign stat_o.valid   = valid_q;
  assign stat_o.ref_bit = ref_q;

  always_comb begin
    valid_d = valid_q;
    ref_d   = ref_q;
    mod_d   = mod_q;
    page_d  = page_q;
    if (ctl_i.go) begin
      if (sel) begin
        ref_d = 1'b1;
        if (ctl_i.mode == MODE_HIT) begin
          mod_d = mod_q | ctl_i.wr;
        end else begin
          valid_d = 1'b1;
          mod_d   = ctl_i.wr;
          page_d  = page_i;
        end
      end else if (ctl_i.mode == MODE_VICM) begin
        ref_d = 1'b0;
      end else if (ctl_i.mode == MODE_VIC1 && !flag_i.c1) begin
        // frames passed by the second scan lose their reference bit
        ref_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      ref_q   <= 1'b0;
      mod_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      ref_q   <= ref_d;
      mod_q   <= mod_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q <= page_d;
  end

endmodule

@@ hw/rtl/enhanced_clock_page_replacement.sv @@
// Top level: row of frame cells with enhanced second-chance victim choice.
//
//  Port group   Dir   Fields (low bit first)
//  s_axis_*     in    page_number[7:0], is_write[8]
//  m_axis_*     out   hit[0], frame_index[2:1], evicted_valid[3],
//                     evicted_page[11:4], evicted_dirty[12]
//
// For each access the hit search, fill and victim pick ripple down the row
// of frame cells and the table updates at the accepting edge.
// The result word sits in an output register; a new access is taken whenever
// that register is empty or being drained, so a stalled sink stalls the input.
// Reset empties all frames and clears reference and modified bits.
module enhanced_clock_page_replacement import ecpr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,   // page_number, is_write
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata    // hit, frame_index, evicted_valid,
                                           // evicted_page, evicted_dirty
);

  logic                 in_acc;
  logic [PAGE_BITS-1:0] page;
  logic                 wr;
  ctl_t                 ctl;
  flag_t                flag [FRAMES+1];
  sel_t                 sel  [FRAMES+1];
  stat_t                stat [FRAMES];
  logic [FRAMES-1:0]    valid_vec, ref_vec;

  logic out_valid_q, out_valid_d;
  res_t res_q, res_d;

  assign page   = s_axis_tdata[PAGE_BITS-1:0];
  assign wr     = s_axis_tdata[PAGE_BITS];
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !out_valid_q || m_axis_tready;

  assign flag[0] = '0;
  assign sel[0]  = '0;

  for (genvar g = 0; g < FRAMES; g++) begin : g_cell
    ecpr_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (IDX_W'(g)),
      .page_i (page),
      .ctl_i  (ctl),
      .flag_i (flag[g]),
      .flag_o (flag[g+1]),
      .sel_i  (sel[g]),
      .sel_o  (sel[g+1]),
      .stat_o (stat[g])
    );
    assign valid_vec[g] = stat[g].valid;
    assign ref_vec[g]   = stat[g].ref_bit;
  end

  always_comb begin
    ctl.go     = in_acc;
    ctl.wr     = wr;
    ctl.any_m0 = flag[FRAMES].m0;
    priority if (flag[FRAMES].hit) ctl.mode = MODE_HIT;
    else if (flag[FRAMES].inv)     ctl.mode = MODE_FILL;
    else if (flag[FRAMES].c0)      ctl.mode = MODE_VIC0;
    else if (flag[FRAMES].c1)      ctl.mode = MODE_VIC1;
    else                           ctl.mode = MODE_VICM;
  end

  always_comb begin
    logic evict;
    evict = (ctl.mode != MODE_HIT) && (ctl.mode != MODE_FILL);
    res_d.hit           = (ctl.mode == MODE_HIT);
    res_d.frame_index   = sel[FRAMES].idx;
    res_d.evicted_valid = evict;
    res_d.evicted_page  = evict ? sel[FRAMES].page : '0;
    res_d.evicted_dirty = evict & sel[FRAMES].dirty;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_acc) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'(res_q);

  // Frames fill in order, so the valid bits always form a run from frame 0
  a_fill_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_vec & (valid_vec + FRAMES'(1))) == '0)
    else $error("valid frames not contiguous from frame 0");

  a_evict_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.evicted_valid) |-> (&valid_vec))
    else $error("eviction reported while frame table not full");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(res_q.hit && res_q.evicted_valid))
    else $error("hit reported together with eviction");

  a_ref_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (ref_vec[res_q.frame_index] && valid_vec[res_q.frame_index]))
    else $error("accessed frame lacks reference bit");

endmodule
